[rtl/drvmix_pkg.sv]
// Package: request and response types, command codes and mixer constants.
package drvmix_pkg;

   // Request payload, one command or tick.
   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  direction_code;
      logic [7:0]  amount;
      logic [15:0] elapsed_us;
   } req_type;

   // Response payload, signed wheel drives in percent.
   typedef struct packed {
      logic signed [7:0] left_drive;
      logic signed [7:0] right_drive;
   } rsp_type;

   // Command codes.
   localparam logic [2:0] OP_SET_DIRECTION = 3'd0;
   localparam logic [2:0] OP_SET_SPEED     = 3'd1;
   localparam logic [2:0] OP_SET_TIMEOUT   = 3'd2;
   localparam logic [2:0] OP_CLEAR_TIMEOUT = 3'd3;
   localparam logic [2:0] OP_TICK          = 3'd4;

   // Direction codes.
   localparam logic [3:0] DIR_NONE       = 4'd0;
   localparam logic [3:0] DIR_FWD        = 4'd1;
   localparam logic [3:0] DIR_BACK       = 4'd2;
   localparam logic [3:0] DIR_LEFT       = 4'd3;
   localparam logic [3:0] DIR_RIGHT      = 4'd4;
   localparam logic [3:0] DIR_FWD_LEFT   = 4'd5;
   localparam logic [3:0] DIR_FWD_RIGHT  = 4'd6;
   localparam logic [3:0] DIR_BACK_LEFT  = 4'd7;
   localparam logic [3:0] DIR_BACK_RIGHT = 4'd8;

   // Level register indexes.
   localparam int unsigned NUM_LEVELS = 5;
   localparam logic [2:0] REG_STRAIGHT    = 3'd0;
   localparam logic [2:0] REG_TURN_INNER  = 3'd1;
   localparam logic [2:0] REG_TURN_OUTER  = 3'd2;
   localparam logic [2:0] REG_LIGHT_INNER = 3'd3;
   localparam logic [2:0] REG_LIGHT_OUTER = 3'd4;

   // Level reset values.
   localparam logic signed [7:0] RST_STRAIGHT    = 8'sd100;
   localparam logic signed [7:0] RST_TURN_INNER  = 8'sd0;
   localparam logic signed [7:0] RST_TURN_OUTER  = 8'sd100;
   localparam logic signed [7:0] RST_LIGHT_INNER = 8'sd50;
   localparam logic signed [7:0] RST_LIGHT_OUTER = 8'sd100;

   // Speed and watchdog constants.
   localparam logic [6:0]  SPEED_MAX   = 7'd100;
   localparam logic [24:0] US_PER_UNIT = 25'd100000;

   // Scaling: clamp to 100.00 percent, round half away, divide by 100.
   localparam logic [13:0] CLAMP_LIMIT = 14'd10000;
   localparam logic [13:0] ROUND_BIAS  = 14'd50;
   localparam logic [26:0] RECIP_100   = 27'd5243;
   localparam int unsigned RECIP_SHIFT = 19;

endpackage

[rtl/drvmix_round.sv]
// Clamp a level-times-speed product, round half away from zero and divide by 100.
module drvmix_round (
   input  logic signed [14:0] product,
   output logic signed [7:0]  drive
);

   logic        negative;
   logic [14:0] magnitude;
   logic [13:0] limited;
   logic [13:0] biased;
   logic [26:0] scaled;
   logic [7:0]  quotient;

   // Take magnitude and clamp to 10000 hundredths
   assign negative  = product[14];
   assign magnitude = negative ? 15'(-product) : 15'(product);
   assign limited   = (magnitude > {1'b0, drvmix_pkg::CLAMP_LIMIT}) ?
                      drvmix_pkg::CLAMP_LIMIT : magnitude[13:0];

   // Divide by 100 through the reciprocal; exact for values up to 10050
   assign biased   = limited + drvmix_pkg::ROUND_BIAS;
   assign scaled   = {13'b0, biased} * drvmix_pkg::RECIP_100;
   assign quotient = scaled[drvmix_pkg::RECIP_SHIFT +: 8];

   // Restore sign
   assign drive = negative ? -$signed(quotient) : $signed(quotient);

endmodule

[rtl/drive_command_mixer_with_watchdog_top.sv]
// Top level: drive command mixer with speed scaling and tick watchdog.
//
//   channel  direction  ports                              payload
//   request  in         req_valid / req_ready / req_data   drvmix_pkg::req_type
//   response out        rsp_valid / rsp_ready / rsp_data   drvmix_pkg::rsp_type
//   config   in         csr_write_en / csr_index / csr_wdata  8-bit level write
//
// One request is accepted per cycle while req_ready is high; a stalled response can
// hold it low. A request that produces a response passes the input register, the
// product register and the output register before rsp_valid rises. The watchdog and
// state update in the input register stage, so back-to-back requests see each other's
// effects. Reset is synchronous and empties all stages. A stalled response holds the
// pipeline only as far back as a stage that carries a response; requests without a
// response keep flowing.
module drive_command_mixer_with_watchdog_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  drvmix_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output drvmix_pkg::rsp_type rsp_data,
   input  logic                csr_write_en,
   input  logic [2:0]          csr_index,
   input  logic [7:0]          csr_wdata
);

   // Configured levels
   logic signed [7:0] level_ff [drvmix_pkg::NUM_LEVELS];

   // Architectural state
   logic [3:0]  dir_ff,     dir_in;
   logic [6:0]  speed_ff,   speed_in;
   logic [24:0] limit_ff,   limit_in;
   logic [24:0] elapsed_ff, elapsed_in;

   // Pipeline stages
   logic                s1_valid_ff;
   drvmix_pkg::req_type s1_req_ff;
   logic                s2_valid_ff;
   logic signed [14:0]  s2_left_ff,  s2_right_ff;
   logic                rsp_valid_ff;
   drvmix_pkg::rsp_type rsp_data_ff;

   logic s3_free, s2_free, s2_advance, s1_advance, s1_emit;
   logic tick_expire;
   logic [25:0] elapsed_sum;
   logic [3:0]  emit_dir;
   logic signed [8:0] straight, turn_in, turn_out, light_in, light_out;
   logic signed [8:0] left_level, right_level;
   logic signed [16:0] left_prod, right_prod;
   logic signed [7:0]  left_drive, right_drive;

   // Stage flow control
   assign s3_free    = !rsp_valid_ff || rsp_ready;
   assign s2_free    = !s2_valid_ff || s3_free;
   assign s2_advance = s2_valid_ff && s3_free;
   assign s1_advance = s1_valid_ff && (!s1_emit || s2_free);
   assign req_ready  = !s1_valid_ff || s1_advance;

   // Watchdog check on the held request
   assign elapsed_sum = {1'b0, elapsed_ff} + {10'b0, s1_req_ff.elapsed_us};
   assign tick_expire = (s1_req_ff.op == drvmix_pkg::OP_TICK) && (limit_ff != 25'd0)
                        && (elapsed_sum[24:0] >= limit_ff);
   assign s1_emit     = (s1_req_ff.op == drvmix_pkg::OP_SET_DIRECTION) || tick_expire;
   assign emit_dir    = (s1_req_ff.op == drvmix_pkg::OP_SET_DIRECTION) ?
                        s1_req_ff.direction_code : drvmix_pkg::DIR_NONE;

   // Widen levels so that negating -128 stays exact
   assign straight  = {level_ff[drvmix_pkg::REG_STRAIGHT][7],
                       level_ff[drvmix_pkg::REG_STRAIGHT]};
   assign turn_in   = {level_ff[drvmix_pkg::REG_TURN_INNER][7],
                       level_ff[drvmix_pkg::REG_TURN_INNER]};
   assign turn_out  = {level_ff[drvmix_pkg::REG_TURN_OUTER][7],
                       level_ff[drvmix_pkg::REG_TURN_OUTER]};
   assign light_in  = {level_ff[drvmix_pkg::REG_LIGHT_INNER][7],
                       level_ff[drvmix_pkg::REG_LIGHT_INNER]};
   assign light_out = {level_ff[drvmix_pkg::REG_LIGHT_OUTER][7],
                       level_ff[drvmix_pkg::REG_LIGHT_OUTER]};

   // Select base level per wheel from the direction
   always_comb begin
      unique case (emit_dir)
         drvmix_pkg::DIR_FWD: begin
            left_level  = straight;
            right_level = straight;
         end
         drvmix_pkg::DIR_BACK: begin
            left_level  = -straight;
            right_level = -straight;
         end
         drvmix_pkg::DIR_LEFT: begin
            left_level  = turn_in;
            right_level = turn_out;
         end
         drvmix_pkg::DIR_RIGHT: begin
            left_level  = turn_out;
            right_level = turn_in;
         end
         drvmix_pkg::DIR_FWD_LEFT: begin
            left_level  = light_in;
            right_level = light_out;
         end
         drvmix_pkg::DIR_FWD_RIGHT: begin
            left_level  = light_out;
            right_level = light_in;
         end
         drvmix_pkg::DIR_BACK_LEFT: begin
            left_level  = -light_out;
            right_level = -light_in;
         end
         drvmix_pkg::DIR_BACK_RIGHT: begin
            left_level  = -light_in;
            right_level = -light_out;
         end
         default: begin
            left_level  = 9'sd0;
            right_level = 9'sd0;
         end
      endcase
   end

   // Scale by speed in hundredths of a percent
   assign left_prod  = left_level  * $signed({1'b0, speed_ff});
   assign right_prod = right_level * $signed({1'b0, speed_ff});

   // Next architectural state for the held request
   always_comb begin
      dir_in     = dir_ff;
      speed_in   = speed_ff;
      limit_in   = limit_ff;
      elapsed_in = elapsed_ff;
      case (s1_req_ff.op)
         drvmix_pkg::OP_SET_DIRECTION: begin
            dir_in = s1_req_ff.direction_code;
         end
         drvmix_pkg::OP_SET_SPEED: begin
            speed_in = (s1_req_ff.amount > {1'b0, drvmix_pkg::SPEED_MAX}) ?
                       drvmix_pkg::SPEED_MAX : s1_req_ff.amount[6:0];
         end
         drvmix_pkg::OP_SET_TIMEOUT: begin
            limit_in   = {17'b0, s1_req_ff.amount} * drvmix_pkg::US_PER_UNIT;
            elapsed_in = 25'd0;
         end
         drvmix_pkg::OP_CLEAR_TIMEOUT: begin
            limit_in   = 25'd0;
            elapsed_in = 25'd0;
         end
         drvmix_pkg::OP_TICK: begin
            if (tick_expire) begin
               elapsed_in = 25'd0;
               dir_in     = drvmix_pkg::DIR_NONE;
            end else if (limit_ff != 25'd0) begin
               elapsed_in = elapsed_sum[24:0];
            end
         end
         default: begin
            dir_in = dir_ff;
         end
      endcase
   end

   // Hold level registers, write on enable
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff[drvmix_pkg::REG_STRAIGHT]    <= drvmix_pkg::RST_STRAIGHT;
         level_ff[drvmix_pkg::REG_TURN_INNER]  <= drvmix_pkg::RST_TURN_INNER;
         level_ff[drvmix_pkg::REG_TURN_OUTER]  <= drvmix_pkg::RST_TURN_OUTER;
         level_ff[drvmix_pkg::REG_LIGHT_INNER] <= drvmix_pkg::RST_LIGHT_INNER;
         level_ff[drvmix_pkg::REG_LIGHT_OUTER] <= drvmix_pkg::RST_LIGHT_OUTER;
      end else if (csr_write_en && (csr_index <= drvmix_pkg::REG_LIGHT_OUTER)) begin
         level_ff[csr_index] <= $signed(csr_wdata);
      end
   end

   // Advance architectural state when the held request leaves stage one
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff     <= drvmix_pkg::DIR_NONE;
         speed_ff   <= drvmix_pkg::SPEED_MAX;
         limit_ff   <= 25'd0;
         elapsed_ff <= 25'd0;
      end else if (s1_advance) begin
         dir_ff     <= dir_in;
         speed_ff   <= speed_in;
         limit_ff   <= limit_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // Stage one: capture request
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_req_ff <= req_data;
      end
   end

   // Stage two: hold products of requests that respond
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_advance && s1_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && s1_advance && s1_emit) begin
         s2_left_ff  <= left_prod[14:0];
         s2_right_ff <= right_prod[14:0];
      end
   end

   // Round both wheels
   drvmix_round u_round_left (
      .product (s2_left_ff),
      .drive   (left_drive)
   );

   drvmix_round u_round_right (
      .product (s2_right_ff),
      .drive   (right_drive)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s3_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_advance) begin
         rsp_data_ff.left_drive  <= left_drive;
         rsp_data_ff.right_drive <= right_drive;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/drvmix_checker.sv]
// Checker: port-level properties of the drive mixer, bound to the top level.
module drvmix_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input drvmix_pkg::rsp_type rsp_data
);

   // Drives stay within plus or minus 100 percent
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.left_drive <= 8'sd100 && rsp_data.left_drive >= -8'sd100
                     && rsp_data.right_drive <= 8'sd100 && rsp_data.right_drive >= -8'sd100))
      else $error("drive out of range");

   // A stalled response holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Requests stall only behind a stalled response
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without output backpressure");

   // No response right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind drive_command_mixer_with_watchdog_top drvmix_checker u_drvmix_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[dv/drive_command_mixer_with_watchdog_top_tb.sv]
// Testbench for the drive command mixer: table-driven and random requests, predicted drives.
`timescale 1ns / 100ps

module drive_command_mixer_with_watchdog_top_tb;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int LATENCY_PAD      = 8;
   localparam int RANDOM_PER_PHASE = 100;
   localparam int NUM_PHASES       = 6;
   localparam int PAUSE_AT         = 50;

   // Op codes the block ignores, and the highest direction code.
   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
   localparam logic [3:0] DIR_UNKNOWN_TOP = 4'd15;

   typedef struct packed {
      drvmix_pkg::req_type req;
      logic                typed;
      drvmix_pkg::rsp_type drives;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   drvmix_pkg::req_type req_data;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   drvmix_pkg::rsp_type rsp_data;
   logic                csr_write_en;
   logic [2:0]          csr_index;
   logic [7:0]          csr_wdata;

   // Predictor state and level copies.
   logic signed [7:0] level_cfg [drvmix_pkg::NUM_LEVELS];
   logic [3:0]  cur_dir;
   logic [6:0]  speed_pct;
   logic [7:0]  wd_units;
   logic [24:0] wd_elapsed;

   drvmix_pkg::rsp_type expected_drives [$];
   stim_row_type        directed_rows [$];
   int      errors = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      cycles = 0;

   drive_command_mixer_with_watchdog_top u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Scale a level by the speed percent: clamp, then round half away from zero.
   function automatic logic signed [7:0] scale_drive(int level);
      int prod;
      int mag;
      prod = level * int'(speed_pct);
      if (prod > int'(drvmix_pkg::CLAMP_LIMIT)) prod = int'(drvmix_pkg::CLAMP_LIMIT);
      if (prod < -int'(drvmix_pkg::CLAMP_LIMIT)) prod = -int'(drvmix_pkg::CLAMP_LIMIT);
      mag = ((prod < 0 ? -prod : prod) + int'(drvmix_pkg::ROUND_BIAS)) / 100;
      return 8'(prod < 0 ? -mag : mag);
   endfunction

   // Pick wheel levels for the current direction and scale both.
   function automatic drvmix_pkg::rsp_type mix_drives();
      int st, ti, to, li, lo;
      int l, r;
      drvmix_pkg::rsp_type d;
      st = level_cfg[drvmix_pkg::REG_STRAIGHT];
      ti = level_cfg[drvmix_pkg::REG_TURN_INNER];
      to = level_cfg[drvmix_pkg::REG_TURN_OUTER];
      li = level_cfg[drvmix_pkg::REG_LIGHT_INNER];
      lo = level_cfg[drvmix_pkg::REG_LIGHT_OUTER];
      case (cur_dir)
         drvmix_pkg::DIR_FWD:        begin l = st;  r = st;  end
         drvmix_pkg::DIR_BACK:       begin l = -st; r = -st; end
         drvmix_pkg::DIR_LEFT:       begin l = ti;  r = to;  end
         drvmix_pkg::DIR_RIGHT:      begin l = to;  r = ti;  end
         drvmix_pkg::DIR_FWD_LEFT:   begin l = li;  r = lo;  end
         drvmix_pkg::DIR_FWD_RIGHT:  begin l = lo;  r = li;  end
         drvmix_pkg::DIR_BACK_LEFT:  begin l = -lo; r = -li; end
         drvmix_pkg::DIR_BACK_RIGHT: begin l = -li; r = -lo; end
         default:                    begin l = 0;   r = 0;   end
      endcase
      d.left_drive  = scale_drive(l);
      d.right_drive = scale_drive(r);
      return d;
   endfunction

   // Advance the predicted state by one request; report whether drives come out.
   function automatic logic predict_request(input drvmix_pkg::req_type r,
                                            output drvmix_pkg::rsp_type drives);
      int unsigned sum;
      int unsigned limit_us;
      drives = '0;
      case (r.op)
         drvmix_pkg::OP_SET_DIRECTION: begin
            cur_dir = r.direction_code;
            drives  = mix_drives();
            return 1'b1;
         end
         drvmix_pkg::OP_SET_SPEED: begin
            speed_pct = (r.amount > drvmix_pkg::SPEED_MAX) ?
                        drvmix_pkg::SPEED_MAX : r.amount[6:0];
         end
         drvmix_pkg::OP_SET_TIMEOUT: begin
            wd_units   = r.amount;
            wd_elapsed = '0;
         end
         drvmix_pkg::OP_CLEAR_TIMEOUT: begin
            wd_units   = '0;
            wd_elapsed = '0;
         end
         drvmix_pkg::OP_TICK: begin
            if (wd_units != 0) begin
               sum        = wd_elapsed + r.elapsed_us;
               wd_elapsed = 25'(sum);
               limit_us   = wd_units * drvmix_pkg::US_PER_UNIT;
               if (wd_elapsed >= limit_us) begin
                  wd_elapsed = '0;
                  cur_dir    = drvmix_pkg::DIR_NONE;
                  drives     = mix_drives();
                  return 1'b1;
               end
            end
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // Offer one request, hold it until accepted, then record what it should produce.
   task automatic send_request(input drvmix_pkg::req_type r, input logic typed,
                               input drvmix_pkg::rsp_type typed_drives);
      drvmix_pkg::rsp_type drives;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (predict_request(r, drives))
         expected_drives.push_back(typed ? typed_drives : drives);
   endtask

   // Drop valid and hold until every predicted drive has come out.
   task automatic wait_for_drives();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_drives.size() != 0);
   endtask

   // Drain, then let requests without drives clear the pipeline.
   task automatic settle_block();
      wait_for_drives();
      repeat (LATENCY_PAD) @(posedge clock);
   endtask

   task automatic write_level(input logic [2:0] idx, input logic [7:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      level_cfg[idx] = value;
   endtask

   task automatic set_levels(input logic [7:0] st, input logic [7:0] ti, input logic [7:0] to,
                             input logic [7:0] li, input logic [7:0] lo);
      write_level(drvmix_pkg::REG_STRAIGHT, st);
      write_level(drvmix_pkg::REG_TURN_INNER, ti);
      write_level(drvmix_pkg::REG_TURN_OUTER, to);
      write_level(drvmix_pkg::REG_LIGHT_INNER, li);
      write_level(drvmix_pkg::REG_LIGHT_OUTER, lo);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_row(input logic [2:0] op, input logic [3:0] dir, input logic [7:0] amount,
                          input logic [15:0] us, input logic typed, input int l, input int r);
      stim_row_type row;
      row.req.op             = op;
      row.req.direction_code = dir;
      row.req.amount         = amount;
      row.req.elapsed_us     = us;
      row.typed              = typed;
      row.drives.left_drive  = 8'(l);
      row.drives.right_drive = 8'(r);
      directed_rows.push_back(row);
   endtask

   function automatic logic [7:0] any_level_in_range();
      int v;
      v = int'($urandom_range(200)) - 100;
      return 8'(v);
   endfunction

   // Mostly well-formed commands: directions, speeds, short watchdogs and ticks.
   function automatic drvmix_pkg::req_type random_request();
      drvmix_pkg::req_type r;
      int                  sel;
      sel              = $urandom_range(99);
      r.direction_code = 4'($urandom);
      r.amount         = 8'($urandom);
      r.elapsed_us     = 16'($urandom);
      if (sel < 35) begin
         r.op = drvmix_pkg::OP_SET_DIRECTION;
         if ($urandom_range(9) < 8)
            r.direction_code = 4'($urandom_range(drvmix_pkg::DIR_BACK_RIGHT));
      end else if (sel < 50) begin
         r.op = drvmix_pkg::OP_SET_SPEED;
         if ($urandom_range(1)) r.amount = 8'($urandom_range(drvmix_pkg::SPEED_MAX));
      end else if (sel < 58) begin
         r.op = drvmix_pkg::OP_SET_TIMEOUT;
         if ($urandom_range(9) < 8) r.amount = 8'($urandom_range(3, 1));
      end else if (sel < 62) begin
         r.op = drvmix_pkg::OP_CLEAR_TIMEOUT;
      end else if (sel < 95) begin
         r.op = drvmix_pkg::OP_TICK;
      end else begin
         r.op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      end
      return r;
   endfunction

   // Check each response against the oldest predicted drives.
   always @(posedge clock) begin : check_drives
      drvmix_pkg::rsp_type want;
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_drives.size() == 0) begin
            $display("%0t: unexpected response expected none got left %0d right %0d",
                     $time, rsp_data.left_drive, rsp_data.right_drive);
            errors++;
         end else begin
            want = expected_drives.pop_front();
            if (rsp_data.left_drive !== want.left_drive) begin
               $display("%0t: left_drive expected %0d got %0d",
                        $time, want.left_drive, rsp_data.left_drive);
               errors++;
            end
            if (rsp_data.right_drive !== want.right_drive) begin
               $display("%0t: right_drive expected %0d got %0d",
                        $time, want.right_drive, rsp_data.right_drive);
               errors++;
            end
         end
      end
   end

   // Bound the run.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      drvmix_pkg::req_type r;
      int                  count;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= drvmix_pkg::REG_STRAIGHT;
      csr_wdata    <= '0;
      reset        <= 1'b1;

      level_cfg[drvmix_pkg::REG_STRAIGHT]    = drvmix_pkg::RST_STRAIGHT;
      level_cfg[drvmix_pkg::REG_TURN_INNER]  = drvmix_pkg::RST_TURN_INNER;
      level_cfg[drvmix_pkg::REG_TURN_OUTER]  = drvmix_pkg::RST_TURN_OUTER;
      level_cfg[drvmix_pkg::REG_LIGHT_INNER] = drvmix_pkg::RST_LIGHT_INNER;
      level_cfg[drvmix_pkg::REG_LIGHT_OUTER] = drvmix_pkg::RST_LIGHT_OUTER;
      cur_dir    = drvmix_pkg::DIR_NONE;
      speed_pct  = drvmix_pkg::SPEED_MAX;
      wd_units   = '0;
      wd_elapsed = '0;

      // Every direction at reset levels, speed clamp and rounding, ignored ops, watchdog.
      add_row(drvmix_pkg::OP_SET_DIRECTION, drvmix_pkg::DIR_NONE, 8'd0, 16'd0, 1'b1, 0, 0);
      add_row(drvmix_pkg::OP_SET_DIRECTION, drvmix_pkg::DIR_FWD, 8'd0, 16'd0, 1'b1,
              100, 100);
      add_row(drvmix_pkg::OP_SET_DIRECTION, drvmix_pkg::DIR_BACK, 8'd0, 16'd0, 1'b1,
              -100, -100);
      add_row(drvmix_pkg::OP_SET_DIRECTION, drvmix_pkg::DIR_LEFT, 8'd0, 16'd0, 1'b1, 0, 100);
      add_row(drvmix_pkg::OP_SET_DIRECTION, drvmix_pkg::DIR_RIGHT, 8'd0, 16'd0, 1'b1,
              100, 0);
      add_row(drvmix_pkg::OP_SET_DIRECTION, drvmix_pkg::DIR_FWD_LEFT, 8'd0, 16'd0, 1'b1,
              50, 100);
      add_row(drvmix_pkg::OP_SET_DIRECTION, drvmix_pkg::DIR_FWD_RIGHT, 8'd0, 16'd0, 1'b1,
              100, 50);
      add_row(drvmix_pkg::OP_SET_DIRECTION, drvmix_pkg::DIR_BACK_LEFT, 8'd0, 16'd0, 1'b1,
              -100, -50);
      add_row(drvmix_pkg::OP_SET_DIRECTION, drvmix_pkg::DIR_BACK_RIGHT, 8'd0, 16'd0, 1'b1,
              -50, -100);
      add_row(drvmix_pkg::OP_SET_DIRECTION, DIR_UNKNOWN_TOP, 8'hFF, 16'hFFFF, 1'b1, 0, 0);
      add_row(drvmix_pkg::OP_SET_SPEED, drvmix_pkg::DIR_NONE, 8'hFF, 16'd0, 1'b0, 0, 0);
      add_row(drvmix_pkg::OP_SET_DIRECTION, drvmix_pkg::DIR_FWD, 8'd0, 16'd0, 1'b1,
              100, 100);
      add_row(drvmix_pkg::OP_SET_SPEED, drvmix_pkg::DIR_NONE, 8'd0, 16'd0, 1'b0, 0, 0);
      add_row(drvmix_pkg::OP_SET_DIRECTION, drvmix_pkg::DIR_BACK, 8'd0, 16'd0, 1'b1, 0, 0);
      add_row(drvmix_pkg::OP_SET_SPEED, drvmix_pkg::DIR_NONE, 8'd33, 16'd0, 1'b0, 0, 0);
      add_row(drvmix_pkg::OP_SET_DIRECTION, drvmix_pkg::DIR_FWD_LEFT, 8'd0, 16'd0, 1'b0,
              0, 0);
      add_row(drvmix_pkg::OP_SET_SPEED, drvmix_pkg::DIR_NONE, 8'd1, 16'd0, 1'b0, 0, 0);
      add_row(drvmix_pkg::OP_SET_DIRECTION, drvmix_pkg::DIR_BACK_LEFT, 8'd0, 16'd0, 1'b0,
              0, 0);
      add_row(OP_UNUSED_LAST, DIR_UNKNOWN_TOP, 8'hFF, 16'hFFFF, 1'b0, 0, 0);
      add_row(drvmix_pkg::OP_SET_TIMEOUT, drvmix_pkg::DIR_NONE, 8'd1, 16'd0, 1'b0, 0, 0);
      add_row(drvmix_pkg::OP_TICK, drvmix_pkg::DIR_NONE, 8'd0, 16'hFFFF, 1'b0, 0, 0);
      add_row(drvmix_pkg::OP_TICK, drvmix_pkg::DIR_NONE, 8'd0, 16'hFFFF, 1'b1, 0, 0);
      add_row(drvmix_pkg::OP_SET_TIMEOUT, drvmix_pkg::DIR_NONE, 8'hFF, 16'd0, 1'b0, 0, 0);
      add_row(drvmix_pkg::OP_CLEAR_TIMEOUT, drvmix_pkg::DIR_NONE, 8'd0, 16'd0, 1'b0, 0, 0);
      add_row(drvmix_pkg::OP_TICK, drvmix_pkg::DIR_NONE, 8'd0, 16'hFFFF, 1'b0, 0, 0);
      add_row(drvmix_pkg::OP_SET_TIMEOUT, drvmix_pkg::DIR_NONE, 8'd0, 16'd0, 1'b0, 0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].drives);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         settle_block();
         if (phase < 2) begin
            send_idle_pct = 34;
            recv_idle_pct = 72;
         end else if (phase < 4) begin
            send_idle_pct = 72;
            recv_idle_pct = 34;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         // Walk the levels through their extremes, then random in-range, fixed and fully random settings.
         case (phase)
            0: set_levels(8'h80, 8'h80, 8'h80, 8'h80, 8'h80);
            1: set_levels(8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F);
            2: set_levels(any_level_in_range(), any_level_in_range(), any_level_in_range(),
                          any_level_in_range(), any_level_in_range());
            3: set_levels(-8'sd100, 8'sd100, -8'sd100, 8'sd0, 8'sd100);
            default: set_levels(8'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom));
         endcase

         count = 0;
         while (count < RANDOM_PER_PHASE) begin
            r = random_request();
            send_request(r, 1'b0, '0);
            if (r.op <= drvmix_pkg::OP_TICK) count++;
            // Hold off until every predicted drive has come out while the count stands at PAUSE_AT.
            if (count == PAUSE_AT) wait_for_drives();
         end
      end

      settle_block();
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
